[hdl/assert_macros.svh]
// Assertion macros shared by the deadband filter RTL.
// Included by the files that check their own logic; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define ADF_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that the consequent holds in the cycle in which the antecedent holds.
`define ADF_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

[hdl/adf_pkg.sv]
// Package of the adaptive deadband filter: constants, register codes and the
// sequencer state type. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package adf_pkg;

   localparam int unsigned WINDOW_MAX_DEF = 1024;
   localparam int unsigned ADDR_W         = 3;
   localparam int unsigned DVD_W          = 32;

   localparam logic [6:0]  TARGET_RESET    = 7'd10;
   localparam logic [31:0] DEV_RESET       = 32'd65536;
   localparam logic [31:0] INFINITE_RATIO  = 32'd10000;
   localparam logic [31:0] LOG2_INV095_Q24 = 32'd1241524;
   localparam logic [31:0] LN2_Q30         = 32'd744261118;
   localparam logic [31:0] ONE_Q30         = 32'h4000_0000;
   localparam logic [3:0]  SERIES_TERMS    = 4'd12;
   // Multiplying by this and keeping bits 63:34 divides a 32-bit value by five.
   localparam logic [31:0] DIV5_RECIP      = 32'hCCCC_CCCD;

   // Register index codes, taken from paddr[2].
   localparam logic REG_TARGET = 1'b0;
   localparam logic REG_INIT   = 1'b1;

   typedef enum logic [3:0] {
      S_IDLE,
      S_KEEP,
      S_WIN,
      S_TK,
      S_CMP,
      S_GROW,
      S_EDIV,
      S_X,
      S_F,
      S_Y,
      S_TM,
      S_TD,
      S_TW,
      S_DM,
      S_SH,
      S_OUT
   } adf_state_type;

endpackage

`default_nettype wire

[hdl/adf_req_if.sv]
// Request channel of the deadband filter: valid/ready and one signed sample.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface adf_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

`default_nettype wire

[hdl/adf_rsp_if.sv]
// Response channel of the deadband filter: valid/ready, keep flag and threshold.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface adf_rsp_if;
   logic        valid;
   logic        ready;
   logic        keep;
   logic [31:0] threshold_now;

   modport source (output valid, output keep, output threshold_now, input ready);
   modport sink   (input valid, input keep, input threshold_now, output ready);
endinterface

`default_nettype wire

[hdl/adf_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module adf_ram #(
   parameter int unsigned WIDTH = 1,
   parameter int unsigned DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

[hdl/adf_div.sv]
// Restoring divider that retires one quotient bit per cycle.
// Uses adf_pkg for the default dividend width.
`timescale 1ns / 1ps
`default_nettype none

module adf_div #(
   parameter int unsigned DVD_W = adf_pkg::DVD_W,
   parameter int unsigned DVS_W = 22
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [DVD_W-1:0] dividend,
   input  wire logic [DVS_W-1:0] divisor,
   output logic                  done,
   output logic      [DVD_W-1:0] quotient
);

   localparam int unsigned CNT_W = $clog2(DVD_W + 1);

   logic             busy_ff;
   logic             done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [DVS_W-1:0] rem_ff;
   logic [DVS_W-1:0] dvs_ff;
   logic [DVD_W-1:0] quo_ff;
   logic [DVS_W:0]   trial;
   logic             fits;

   assign trial = {rem_ff, quo_ff[DVD_W-1]};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(DVD_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= fits ? DVS_W'(trial - {1'b0, dvs_ff}) : trial[DVS_W-1:0];
         quo_ff <= {quo_ff[DVD_W-2:0], fits};
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

[hdl/adaptive_deadband_filter_unit.sv]
// Top level of the adaptive deadband filter: sequencer, shared multiplier,
// keep-window RAM and divider. Depends on adf_pkg, adf_req_if, adf_rsp_if,
// adf_ram, adf_div and assert_macros.svh.
//
// Usage: each request on req_ch carries one signed Q16.16 sample. For every
// request exactly one response leaves on rsp_ch with the keep flag and the
// threshold after this sample's adaptation. The block handles one request at
// a time and holds req_ch.ready low while it works.
// The response follows the states KEEP, WIN and TK directly while the window is
// less than a tenth full, passes CMP as well when the ratio lies within its
// bounds, adds GROW when the threshold grows by 5 percent (one pass through the
// shared multiplier), and runs the shrink path when it shrinks: the shrink runs one
// quotient division and twelve series-term divisions through the shared
// divider, which retires one quotient bit per cycle. A new request is accepted
// only once the response of the last one is in the output register.
// The response sits in an output register; if the receiver stalls, the next
// request is still accepted and its processing waits only at the final step.
// Reset, and any configuration write over the APB port, clears the window,
// zeroes the last kept value and reloads the threshold from initial_deviation.
// The window store needs no clearing pass: its fill count ensures an entry is
// only read after it was written since the last restart.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module adaptive_deadband_filter_unit #(
   parameter int unsigned WINDOW_MAX = adf_pkg::WINDOW_MAX_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   adf_req_if.sink                          req_ch,
   adf_rsp_if.source                        rsp_ch,
   input  wire logic                        psel,
   input  wire logic                        penable,
   input  wire logic                        pwrite,
   input  wire logic [adf_pkg::ADDR_W-1:0]  paddr,
   input  wire logic [31:0]                 pwdata,
   output logic      [31:0]                 prdata,
   output logic                             pready
);
   import adf_pkg::*;

   localparam int unsigned PTR_W  = $clog2(WINDOW_MAX);
   localparam int unsigned FILL_W = $clog2(WINDOW_MAX + 1);
   localparam int unsigned TMAX   = WINDOW_MAX / 10;
   localparam int unsigned T_W    = $clog2(TMAX + 1);
   localparam int unsigned TK_W   = FILL_W + T_W;
   localparam int unsigned CMP_W  = TK_W + 7;

   // Architectural state.
   adf_state_type      state_ff, state_in;
   logic [6:0]         target_ff;
   logic [31:0]        init_ff;
   logic [PTR_W-1:0]   ptr_ff;
   logic [FILL_W-1:0]  fill_ff;
   logic [FILL_W-1:0]  kept_ff;
   logic [31:0]        last_ff;
   logic [31:0]        dev_ff;
   logic               rsp_valid_ff;

   // Working registers of one request.
   logic [31:0]        sample_ff;
   logic               keep_ff;
   logic [63:0]        prod_ff;
   logic [10:0]        n_ff;
   logic [29:0]        y_ff;
   logic [30:0]        term_ff;
   logic [31:0]        sum_ff;
   logic [3:0]         k_ff;
   logic               rsp_keep_ff;
   logic [31:0]        rsp_thr_ff;

   logic [T_W-1:0]     t_eff;
   logic [FILL_W-1:0]  cap;
   logic signed [32:0] diff;
   logic [32:0]        mag;
   logic               keep_in;
   logic               win_full;
   logic               rd_bit;
   logic [FILL_W-1:0]  ptr_next;
   logic               fill_small;
   logic [TK_W-1:0]    tk;
   logic [CMP_W-1:0]   fill100;
   logic [CMP_W-1:0]   lo_bound;
   logic [CMP_W-1:0]   hi_bound;
   logic               below;
   logic               above;
   logic [32:0]        grow_base;
   logic [32:0]        grow_sum;
   logic [31:0]        mul_a;
   logic [31:0]        mul_b;
   logic               div_start;
   logic [DVD_W-1:0]   div_dividend;
   logic [TK_W-1:0]    div_divisor;
   logic               div_done;
   logic [DVD_W-1:0]   div_quo;
   logic [31:0]        shr_val;
   logic [31:0]        p_val;
   logic               out_load;
   logic               cfg_wr;

   // Effective target clamped to [1, WINDOW_MAX/10]; the window holds ten times it.
   always_comb begin
      if (target_ff == 7'd0) begin
         t_eff = T_W'(1);
      end else if (32'(target_ff) > TMAX) begin
         t_eff = T_W'(TMAX);
      end else begin
         t_eff = T_W'(target_ff);
      end
   end

   assign cap = FILL_W'(32'(t_eff) * 32'd10);

   // Keep decision: the first sample after a restart is always kept.
   assign diff    = {sample_ff[31], sample_ff} - {last_ff[31], last_ff};
   assign mag     = diff[32] ? 33'(-diff) : 33'(diff);
   assign keep_in = (fill_ff == '0) || (mag > {1'b0, dev_ff});

   assign win_full   = fill_ff == cap;
   assign ptr_next   = FILL_W'(ptr_ff) + FILL_W'(1);
   assign fill_small = (32'(fill_ff) * 32'd10) < 32'(cap);

   // Exact ratio tests against 0.95 and 1.05 times the target.
   assign tk       = prod_ff[TK_W-1:0];
   assign fill100  = CMP_W'(fill_ff) * CMP_W'(100);
   assign lo_bound = CMP_W'(tk) * CMP_W'(95);
   assign hi_bound = CMP_W'(tk) * CMP_W'(105);
   assign below    = (kept_ff != '0) && (fill100 < lo_bound);
   assign above    = (kept_ff == '0) || (fill100 > hi_bound);

   // Growth by 5 percent rounded up is dev + ceil(dev/20). The quotient
   // ceil(dev/20) = floor(floor((dev + 19)/4)/5) comes from the multiplier.
   assign grow_base = {1'b0, dev_ff} + 33'd19;
   assign grow_sum  = {1'b0, dev_ff} + 33'(prod_ff[63:34]);

   assign p_val   = prod_ff[61:30];
   assign shr_val = (n_ff > 11'd31) ? 32'd0 : (p_val >> n_ff[4:0]);

   assign out_load = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_ch.ready);
   assign cfg_wr   = psel && penable && pwrite && pready;

   // Next-state logic of the sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               state_in = S_KEEP;
            end
         end
         S_KEEP: state_in = S_WIN;
         S_WIN:  state_in = S_TK;
         S_TK: begin
            state_in = fill_small ? S_OUT : S_CMP;
         end
         S_CMP: begin
            if (below) begin
               state_in = S_GROW;
            end else if (above) begin
               state_in = S_EDIV;
            end else begin
               state_in = S_OUT;
            end
         end
         S_GROW: state_in = S_OUT;
         S_EDIV: begin
            if (div_done) begin
               state_in = S_X;
            end
         end
         S_X:  state_in = S_F;
         S_F:  state_in = S_Y;
         S_Y:  state_in = S_TM;
         S_TM: state_in = S_TD;
         S_TD: state_in = S_TW;
         S_TW: begin
            if (div_done) begin
               state_in = (k_ff == SERIES_TERMS) ? S_DM : S_TM;
            end
         end
         S_DM: state_in = S_SH;
         S_SH: state_in = S_OUT;
         S_OUT: begin
            if (out_load) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Output logic of the sequencer: handshake, multiplier and divider operands.
   always_comb begin
      req_ch.ready = 1'b0;
      mul_a        = '0;
      mul_b        = '0;
      div_start    = 1'b0;
      div_dividend = '0;
      div_divisor  = '0;
      case (state_ff)
         S_IDLE: req_ch.ready = 1'b1;
         S_TK: begin
            mul_a = 32'(t_eff);
            mul_b = 32'(kept_ff);
         end
         S_CMP: begin
            if (below) begin
               mul_a = 32'(grow_base >> 2);
               mul_b = DIV5_RECIP;
            end else if (above) begin
               div_start = 1'b1;
               if (kept_ff == '0) begin
                  div_dividend = DVD_W'(INFINITE_RATIO) << 16;
                  div_divisor  = TK_W'(t_eff);
               end else begin
                  div_dividend = DVD_W'(fill_ff) << 16;
                  div_divisor  = tk;
               end
            end
         end
         S_X: begin
            mul_a = div_quo[31:0];
            mul_b = LOG2_INV095_Q24;
         end
         S_F: begin
            mul_a = 32'(prod_ff[39:24]);
            mul_b = LN2_Q30;
         end
         S_TM: begin
            mul_a = 32'(term_ff);
            mul_b = 32'(y_ff);
         end
         S_TD: begin
            div_start    = 1'b1;
            div_dividend = DVD_W'(prod_ff[60:30]);
            div_divisor  = TK_W'(k_ff);
         end
         S_DM: begin
            mul_a = dev_ff;
            mul_b = sum_ff;
         end
         default: begin
            req_ch.ready = 1'b0;
         end
      endcase
   end

   // Control and architectural state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         target_ff    <= TARGET_RESET;
         init_ff      <= DEV_RESET;
         ptr_ff       <= '0;
         fill_ff      <= '0;
         kept_ff      <= '0;
         last_ff      <= '0;
         dev_ff       <= DEV_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;

         if (rsp_valid_ff && rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end

         if (state_ff == S_WIN) begin
            fill_ff <= win_full ? fill_ff : fill_ff + 1'b1;
            kept_ff <= kept_ff - FILL_W'(win_full && rd_bit) + FILL_W'(keep_ff);
            ptr_ff  <= (ptr_next >= cap) ? '0 : PTR_W'(ptr_next);
            if (keep_ff) begin
               last_ff <= sample_ff;
            end
         end

         // Growth saturates at the largest threshold.
         if (state_ff == S_GROW) begin
            dev_ff <= grow_sum[32] ? '1 : grow_sum[31:0];
         end
         if (state_ff == S_SH) begin
            dev_ff <= (shr_val == '0) ? 32'd1 : shr_val;
         end

         // A register write restarts the filter.
         if (cfg_wr) begin
            ptr_ff  <= '0;
            fill_ff <= '0;
            kept_ff <= '0;
            last_ff <= '0;
            if (paddr[2] == REG_INIT) begin
               init_ff <= pwdata;
               dev_ff  <= (pwdata == '0) ? 32'd1 : pwdata;
            end else begin
               target_ff <= pwdata[6:0];
               dev_ff    <= (init_ff == '0) ? 32'd1 : init_ff;
            end
         end
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      prod_ff <= 64'(mul_a) * 64'(mul_b);
      if (req_ch.valid && req_ch.ready) begin
         sample_ff <= req_ch.sample;
      end
      if (state_ff == S_KEEP) begin
         keep_ff <= keep_in;
      end
      if (state_ff == S_F) begin
         n_ff <= prod_ff[50:40];
      end
      if (state_ff == S_Y) begin
         y_ff    <= prod_ff[45:16];
         term_ff <= ONE_Q30[30:0];
         sum_ff  <= ONE_Q30;
         k_ff    <= 4'd1;
      end
      if (state_ff == S_TW && div_done) begin
         term_ff <= div_quo[30:0];
         sum_ff  <= k_ff[0] ? sum_ff - 32'(div_quo[30:0]) : sum_ff + 32'(div_quo[30:0]);
         k_ff    <= k_ff + 4'd1;
      end
      if (out_load) begin
         rsp_keep_ff <= keep_ff;
         rsp_thr_ff  <= dev_ff;
      end
   end

   adf_ram #(
      .WIDTH (1),
      .DEPTH (WINDOW_MAX)
   ) u_window (
      .clock   (clock),
      .wr_en   (state_ff == S_WIN),
      .wr_addr (ptr_ff),
      .wr_data (keep_ff),
      .rd_addr (ptr_ff),
      .rd_data (rd_bit)
   );

   adf_div #(
      .DVD_W (DVD_W),
      .DVS_W (TK_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.keep          = rsp_keep_ff;
   assign rsp_ch.threshold_now = rsp_thr_ff;

   assign pready = 1'b1;
   assign prdata = (paddr[2] == REG_INIT) ? init_ff : {25'd0, target_ff};

   `ADF_ASSERT(a_kept_le_fill, clock, reset, kept_ff <= fill_ff, "kept count above fill")
   `ADF_ASSERT(a_ptr_in_window, clock, reset, FILL_W'(ptr_ff) < cap, "pointer outside window")
   `ADF_ASSERT(a_dev_nonzero, clock, reset, dev_ff != '0, "threshold dropped to zero")
   `ADF_ASSERT_IMPLY(a_done_waiting, clock, reset, div_done, state_ff == S_EDIV || state_ff == S_TW, "divider result with no consumer")

endmodule

`default_nettype wire
